// ===== rtl/clnws_pkg.sv =====
// shared types, constants and phase tables for the character display sequencer
package clnws_pkg;

    localparam int unsigned QueueDepthDefault = 4;

    localparam int unsigned CfgIndexWidth = 2;
    localparam int unsigned CfgDataWidth  = 16;
    localparam int unsigned WaitWidth     = 16;
    localparam int unsigned ShortWaitWidth = 15;

    // init sequence: one lead-in phase, four raw nibbles, four command bytes
    localparam int unsigned InitPhases    = 25;
    localparam int unsigned RawFirstPhase = 1;
    localparam int unsigned CmdFirstPhase = 9;
    localparam int unsigned PhaseWidth    = 5;

    localparam logic [7:0] CursorRow0Base = 8'h80;
    localparam logic [7:0] CursorRow1Base = 8'hC0;
    localparam logic [3:0] RawNibbleWake  = 4'h3;
    localparam logic [3:0] RawNibbleFour  = 4'h2;

    typedef enum logic [1:0] {
        KIND_INIT    = 2'd0,
        KIND_COMMAND = 2'd1,
        KIND_DATA    = 2'd2,
        KIND_CURSOR  = 2'd3
    } t_kind;

    typedef enum logic [CfgIndexWidth-1:0] {
        CFG_ENABLE_WAIT    = 2'd0,
        CFG_BYTE_WAIT      = 2'd1,
        CFG_POWERUP_WAIT   = 2'd2,
        CFG_INIT_STEP_WAIT = 2'd3
    } t_cfg_index;

    // classified request handed from front to back
    typedef struct packed {
        logic       init;
        logic       rs;
        logic [7:0] byte_val;
    } t_job;

    typedef struct packed {
        logic                     we;
        logic [CfgIndexWidth-1:0] index;
        logic [CfgDataWidth-1:0]  data;
    } t_cfg_write;

    // init command bytes, in send order
    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h28;
            2'd1:    b = 8'h0C;
            2'd2:    b = 8'h06;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/clnws_front.sv =====
// front end: accepts requests and turns each into a byte or init job
module clnws_front
    import clnws_pkg::*;
(
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_byte_value,
    input  logic       i_row,
    input  logic [5:0] i_col,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [7:0] cursor_cmd;

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // set-address command: row base plus column, which always fits in eight bits
    assign cursor_cmd = (i_row ? CursorRow1Base : CursorRow0Base) + {2'b00, i_col};

    always_comb begin
        o_job = '0;
        unique case (t_kind'(i_kind))
            KIND_INIT: begin
                o_job.init = 1'b1;
            end
            KIND_COMMAND: begin
                o_job.byte_val = i_byte_value;
            end
            KIND_DATA: begin
                o_job.rs       = 1'b1;
                o_job.byte_val = i_byte_value;
            end
            KIND_CURSOR: begin
                o_job.byte_val = cursor_cmd;
            end
            default: begin
                o_job = '0;
            end
        endcase
    end

endmodule

// ===== rtl/clnws_queue.sv =====
// short job queue between front and back ends
module clnws_queue
    import clnws_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job,
    output logic o_full
);

    localparam int unsigned PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CountWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0]   PtrLast  = PtrWidth'(DEPTH - 1);
    localparam logic [CountWidth-1:0] CountMax = CountWidth'(DEPTH);

    t_job                  r_store [DEPTH];
    logic [PtrWidth-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PtrWidth-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CountWidth-1:0] r_count, n_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CountMax);
    assign o_job   = r_store[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_store[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/clnws_back.sv =====
// back end: wait registers and the pin phase sequencer with its output register
module clnws_back
    import clnws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg_write           i_cfg,
    input  logic                 i_job_valid,
    input  t_job                 i_job,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_rs_level,
    output logic [3:0]           o_data_nibble,
    output logic                 o_enable_level,
    output logic [WaitWidth-1:0] o_wait_units,
    output logic                 o_last
);

    logic [ShortWaitWidth-1:0] r_enable_wait;
    logic [ShortWaitWidth-1:0] r_byte_wait;
    logic [WaitWidth-1:0]      r_powerup_wait;
    logic [ShortWaitWidth-1:0] r_init_step_wait;

    logic [PhaseWidth-1:0] r_phase;
    logic [3:0]            r_nibble_held;

    logic                 r_out_valid;
    logic                 r_rs_level;
    logic [3:0]           r_data_nibble;
    logic                 r_enable_level;
    logic [WaitWidth-1:0] r_wait_units;
    logic                 r_last;

    logic                  advance;
    logic                  emit;
    logic [PhaseWidth-1:0] raw_ofs;
    logic [PhaseWidth-1:0] cmd_ofs;
    logic [7:0]            cur_byte;
    logic [1:0]            byte_sub;
    logic                  p_rs;
    logic [3:0]            p_nibble;
    logic                  p_enable;
    logic [WaitWidth-1:0]  p_wait;
    logic                  p_last;
    logic [WaitWidth-1:0]  enable_wait_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_wait    <= ShortWaitWidth'(2);
            r_byte_wait      <= ShortWaitWidth'(5);
            r_powerup_wait   <= WaitWidth'(500);
            r_init_step_wait <= ShortWaitWidth'(50);
        end else if (i_cfg.we) begin
            unique case (t_cfg_index'(i_cfg.index))
                CFG_ENABLE_WAIT:    r_enable_wait    <= i_cfg.data[ShortWaitWidth-1:0];
                CFG_BYTE_WAIT:      r_byte_wait      <= i_cfg.data[ShortWaitWidth-1:0];
                CFG_POWERUP_WAIT:   r_powerup_wait   <= i_cfg.data;
                CFG_INIT_STEP_WAIT: r_init_step_wait <= i_cfg.data[ShortWaitWidth-1:0];
                default: begin
                end
            endcase
        end
    end

    assign advance = !r_out_valid || !i_out_stall;
    assign emit    = i_job_valid && advance;
    assign o_pop   = emit && p_last;

    assign enable_wait_ext = {1'b0, r_enable_wait};
    assign raw_ofs = r_phase - PhaseWidth'(RawFirstPhase);
    assign cmd_ofs = r_phase - PhaseWidth'(CmdFirstPhase);

    // byte phases: high nibble then low, each enable high then low
    assign cur_byte = i_job.init ? init_cmd(cmd_ofs[3:2]) : i_job.byte_val;
    assign byte_sub = i_job.init ? cmd_ofs[1:0] : r_phase[1:0];

    always_comb begin
        p_rs     = i_job.rs && !i_job.init;
        p_nibble = byte_sub[1] ? cur_byte[3:0] : cur_byte[7:4];
        p_enable = !byte_sub[0];
        p_wait   = enable_wait_ext
                 + ((byte_sub == 2'd3) ? {1'b0, r_byte_wait} : '0);
        p_last   = i_job.init ? (r_phase == PhaseWidth'(InitPhases - 1))
                              : (byte_sub == 2'd3);
        if (i_job.init) begin
            if (r_phase == '0) begin
                // lead-in keeps whatever nibble was last on the pins
                p_nibble = r_nibble_held;
                p_enable = 1'b0;
                p_wait   = r_powerup_wait;
            end else if (r_phase < PhaseWidth'(CmdFirstPhase)) begin
                p_nibble = (raw_ofs[2:1] == 2'd3) ? RawNibbleFour : RawNibbleWake;
                p_enable = !raw_ofs[0];
                p_wait   = enable_wait_ext
                         + (raw_ofs[0] ? {1'b0, r_init_step_wait} : '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_nibble_held <= '0;
            r_out_valid   <= 1'b0;
        end else if (emit) begin
            r_phase       <= p_last ? '0 : r_phase + 1'b1;
            r_nibble_held <= p_nibble;
            r_out_valid   <= 1'b1;
        end else if (advance) begin
            r_out_valid   <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_rs_level     <= p_rs;
            r_data_nibble  <= p_nibble;
            r_enable_level <= p_enable;
            r_wait_units   <= p_wait;
            r_last         <= p_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_rs_level     = r_rs_level;
    assign o_data_nibble  = r_data_nibble;
    assign o_enable_level = r_enable_level;
    assign o_wait_units   = r_wait_units;
    assign o_last         = r_last;

endmodule

// ===== rtl/char_lcd_nibble_write_sequencer.sv =====
// top level of the character display 4-bit write sequencer
// Each accepted request becomes a run of pin phases (RS, D4..D7, enable, hold
// time), one phase per clock from the back end's output register while the
// output is not stalled: a command, data or cursor request takes four phases
// and the init request 25. Requests are classified on entry and held in a
// QUEUE_DEPTH-entry job queue, so new requests are taken while earlier ones
// are still being played out; the input stalls only when that queue is full.
// The hold times come from four wait registers, which should be written only
// while idle.
module char_lcd_nibble_write_sequencer
    import clnws_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CfgIndexWidth-1:0] i_cfg_index,
    input  logic [CfgDataWidth-1:0]  i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_kind,
    input  logic [7:0]               i_byte_value,
    input  logic                     i_row,
    input  logic [5:0]               i_col,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_rs_level,
    output logic [3:0]               o_data_nibble,
    output logic                     o_enable_level,
    output logic [WaitWidth-1:0]     o_wait_units,
    output logic                     o_last
);

    t_cfg_write cfg;
    t_job       front_job;
    t_job       head_job;
    logic       push;
    logic       pop;
    logic       queue_full;
    logic       head_valid;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    clnws_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_byte_value (i_byte_value),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (front_job)
    );

    clnws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_job   (head_job),
        .o_full  (queue_full)
    );

    clnws_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_job_valid    (head_valid),
        .i_job          (head_job),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_rs_level     (o_rs_level),
        .o_data_nibble  (o_data_nibble),
        .o_enable_level (o_enable_level),
        .o_wait_units   (o_wait_units),
        .o_last         (o_last)
    );

endmodule

// ===== rtl/clnws_checker.sv =====
// port-level checks for the character display sequencer, bound to the top level
module clnws_checker
    import clnws_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_rs_level,
    input logic [3:0]           o_data_nibble,
    input logic                 o_enable_level,
    input logic [WaitWidth-1:0] o_wait_units,
    input logic                 o_last
);

    // a stalled transaction keeps its phase
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable(o_rs_level) && $stable(o_data_nibble)
            && $stable(o_enable_level) && $stable(o_wait_units) && $stable(o_last))
        else $error("output phase changed while stalled");

    // every request ends with the enable pin low
    a_last_enable_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> !o_enable_level)
        else $error("final phase leaves enable high");

    // no phase is offered straight out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind char_lcd_nibble_write_sequencer clnws_checker u_clnws_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_rs_level     (o_rs_level),
    .o_data_nibble  (o_data_nibble),
    .o_enable_level (o_enable_level),
    .o_wait_units   (o_wait_units),
    .o_last         (o_last)
);
